// ===== sv/keyword_substitution_cipher_top_macros.svh =====
// assertion macros for the keyword cipher checker
`ifndef KEYWORD_SUBSTITUTION_CIPHER_TOP_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define KWC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyword cipher check failed");

// next-cycle implication
`define KWC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyword cipher check failed");

`endif

// ===== sv/kwc_pkg.sv =====
package kwc_pkg;

	localparam int unsigned ALPHA_LEN = 26;
	localparam int unsigned IDX_W = $clog2(ALPHA_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHA_LEN - 1);
	localparam logic [7:0] UPPER_BASE = 8'd65;
	localparam logic [7:0] LOWER_BASE = 8'd97;

	localparam logic [2:0] MODE_CLEAR  = 3'd0;
	localparam logic [2:0] MODE_KEY    = 3'd1;
	localparam logic [2:0] MODE_FINISH = 3'd2;
	localparam logic [2:0] MODE_ENC    = 3'd3;
	localparam logic [2:0] MODE_DEC    = 3'd4;

	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_CLEAR = 3'd1;
	localparam logic [2:0] OP_KEY   = 3'd2;
	localparam logic [2:0] OP_FILL  = 3'd3;
	localparam logic [2:0] OP_ENC   = 3'd4;
	localparam logic [2:0] OP_DEC   = 3'd5;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] char_in;
	} request_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       not_ready;
	} result_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [IDX_W-1:0] fill_idx;
		logic             set_ready;
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
	} dp_status_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} letter_t;

	function automatic letter_t letter_index(input logic [7:0] c);
		letter_t r;
		r.valid = 1'b0;
		r.idx   = '0;
		if (c >= UPPER_BASE && c < UPPER_BASE + 8'(ALPHA_LEN)) begin
			r.valid = 1'b1;
			r.idx   = IDX_W'(c - UPPER_BASE);
		end else if (c >= LOWER_BASE && c < LOWER_BASE + 8'(ALPHA_LEN)) begin
			r.valid = 1'b1;
			r.idx   = IDX_W'(c - LOWER_BASE);
		end
		return r;
	endfunction

endpackage

// ===== sv/kwc_ctrl.sv =====
module kwc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2:0]            mode,
	input  kwc_pkg::dp_status_t   status,
	output kwc_pkg::ctl_cmd_t     cmd,
	output logic                  busy
);
	import kwc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_FILL = 1'b1;

	logic             state_q;
	logic [IDX_W-1:0] step_q;
	logic             accept;

	assign busy   = (state_q == ST_FILL);
	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		cmd.op        = OP_NONE;
		cmd.fill_idx  = step_q;
		cmd.set_ready = 1'b0;
		if (state_q == ST_FILL) begin
			cmd.op        = OP_FILL;
			cmd.set_ready = status.full || (step_q == LAST_IDX);
		end else if (accept) begin
			unique case (mode)
				MODE_CLEAR: cmd.op = OP_CLEAR;
				MODE_KEY:   cmd.op = OP_KEY;
				MODE_ENC:   cmd.op = OP_ENC;
				MODE_DEC:   cmd.op = OP_DEC;
				default:    cmd.op = OP_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && mode == MODE_FINISH) begin
						state_q <= ST_FILL;
						step_q  <= '0;
					end
				end
				ST_FILL: begin
					if (cmd.set_ready) begin
						state_q <= ST_IDLE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/kwc_datapath.sv =====
module kwc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  kwc_pkg::ctl_cmd_t   cmd,
	input  logic [7:0]          char_in,
	output kwc_pkg::dp_status_t status,
	output logic                done,
	output kwc_pkg::result_t    result
);
	import kwc_pkg::*;

	logic [IDX_W-1:0] table_q [ALPHA_LEN];
	logic [IDX_W-1:0] inv_q   [ALPHA_LEN];
	logic [ALPHA_LEN-1:0] used_q;
	logic [IDX_W-1:0] fill_q;
	logic             ready_q;
	logic             done_q;
	result_t          result_q;

	letter_t          key_let;
	letter_t          dec_let;
	logic [IDX_W-1:0] app_idx;
	logic             app_en;
	logic             full;
	result_t          res_d;

	assign key_let = letter_index(char_in);
	assign full    = (fill_q == IDX_W'(ALPHA_LEN));

	// decrypt takes upper case only
	always_comb begin
		dec_let = key_let;
		if (char_in >= LOWER_BASE) begin
			dec_let.valid = 1'b0;
		end
	end

	always_comb begin
		app_idx = key_let.idx;
		app_en  = 1'b0;
		if (cmd.op == OP_FILL) begin
			app_idx = cmd.fill_idx;
			app_en  = !used_q[cmd.fill_idx] && !full;
		end else if (cmd.op == OP_KEY) begin
			app_en = key_let.valid && !used_q[key_let.idx] && !full;
		end
	end

	always_comb begin
		res_d.char_out  = char_in;
		res_d.not_ready = !ready_q;
		if (ready_q) begin
			if (cmd.op == OP_ENC && key_let.valid) begin
				res_d.char_out = UPPER_BASE + {3'b000, table_q[key_let.idx]};
			end else if (cmd.op == OP_DEC && dec_let.valid) begin
				res_d.char_out = UPPER_BASE + {3'b000, inv_q[dec_let.idx]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			fill_q  <= '0;
			ready_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_ENC) || (cmd.op == OP_DEC);
			if (cmd.op == OP_CLEAR) begin
				used_q  <= '0;
				fill_q  <= '0;
				ready_q <= 1'b0;
			end else begin
				if (app_en) begin
					used_q[app_idx] <= 1'b1;
					fill_q          <= fill_q + 1'b1;
				end
				if (cmd.set_ready) begin
					ready_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (app_en) begin
			table_q[fill_q] <= app_idx;
			inv_q[app_idx]  <= fill_q;
		end
		result_q <= res_d;
	end

	assign status.full = full;
	assign done        = done_q;
	assign result      = result_q;

endmodule

// ===== sv/keyword_substitution_cipher_top.sv =====
// keyword substitution cipher, one request per accepted start
// encrypt and decrypt: result strobed in the cycle after accept, one request per cycle while not busy
// clear and key character: no result; start may follow at once
// finish: busy while the fill sequencer walks the alphabet
// results cannot be stalled; asynchronous active-low reset empties the key
module keyword_substitution_cipher_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  kwc_pkg::request_t  request,
	output logic               busy,
	output logic               done,
	output kwc_pkg::result_t   result
);
	import kwc_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	kwc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (request.mode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	kwc_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.char_in (request.char_in),
		.status  (status),
		.done    (done),
		.result  (result)
	);

endmodule

// ===== sv/kwc_checker.sv =====
`include "keyword_substitution_cipher_top_macros.svh"

module kwc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input kwc_pkg::request_t request,
	input logic              busy,
	input logic              done,
	input kwc_pkg::result_t  result
);
	import kwc_pkg::*;

	logic cipher_acc;

	assign cipher_acc = start && !busy &&
		((request.mode == MODE_ENC) || (request.mode == MODE_DEC));

	// busy only after a finish request
	`KWC_ASSERT_SAME(a_busy_after_finish, $rose(busy), $past(start && request.mode == MODE_FINISH))
	// every cipher request gives a result
	`KWC_ASSERT_NEXT(a_cipher_result, cipher_acc, done)
	// no result without a cipher request
	`KWC_ASSERT_SAME(a_no_spurious, done, $past(cipher_acc))
	// key not ready: byte passes through
	`KWC_ASSERT_SAME(a_pass_through, done && result.not_ready, result.char_out == $past(request.char_in))

endmodule

bind keyword_substitution_cipher_top kwc_checker u_kwc_checker (.*);

// ===== tb/sv/cipher_checker.sv =====
module cipher_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  kwc_pkg::request_t request,
	input  logic              busy,
	input  logic              done,
	input  kwc_pkg::result_t  result,
	output int unsigned       mismatch_count,
	output int unsigned       pending_results
);
	import kwc_pkg::*;

	logic [4:0]           key_table [ALPHA_LEN];
	logic [ALPHA_LEN-1:0] letter_seen;
	logic [4:0]           filled;
	logic                 key_ready;
	result_t              expected_results [$];

	function automatic bit alpha_pos(input logic [7:0] c, output logic [4:0] pos);
		pos = '0;
		if (c >= UPPER_BASE && c < UPPER_BASE + 8'(ALPHA_LEN)) begin
			pos = 5'(c - UPPER_BASE);
			return 1'b1;
		end
		if (c >= LOWER_BASE && c < LOWER_BASE + 8'(ALPHA_LEN)) begin
			pos = 5'(c - LOWER_BASE);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic add_letter(input logic [4:0] pos);
		if (!letter_seen[pos] && filled < 5'(ALPHA_LEN)) begin
			letter_seen[pos] = 1'b1;
			key_table[filled] = pos;
			filled = filled + 5'd1;
		end
	endtask

	task automatic predict_cipher(input request_t req);
		result_t    r;
		logic [4:0] pos;
		r.char_out  = req.char_in;
		r.not_ready = 1'b0;
		case (req.mode)
			MODE_CLEAR: begin
				letter_seen = '0;
				filled      = '0;
				key_ready   = 1'b0;
			end
			MODE_KEY: begin
				if (alpha_pos(req.char_in, pos))
					add_letter(pos);
			end
			MODE_FINISH: begin
				for (int j = 0; j < ALPHA_LEN; j++)
					add_letter(5'(j));
				key_ready = 1'b1;
			end
			MODE_ENC, MODE_DEC: begin
				if (!key_ready) begin
					r.not_ready = 1'b1;
				end else if (req.mode == MODE_ENC) begin
					if (alpha_pos(req.char_in, pos))
						r.char_out = UPPER_BASE + 8'(key_table[pos]);
				end else if (req.char_in >= UPPER_BASE &&
						req.char_in < UPPER_BASE + 8'(ALPHA_LEN)) begin
					for (int j = 0; j < ALPHA_LEN; j++)
						if (key_table[j] == 5'(req.char_in - UPPER_BASE))
							r.char_out = UPPER_BASE + 8'(j);
				end
				expected_results.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			letter_seen = '0;
			filled      = '0;
			key_ready   = 1'b0;
			expected_results.delete();
			mismatch_count  <= 0;
			pending_results <= 0;
		end else begin
			if (start && !busy)
				predict_cipher(request);
			if (done) begin
				if (expected_results.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result: char_out %h not_ready %b",
							result.char_out, result.not_ready);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (result.char_out !== want.char_out ||
							result.not_ready !== want.not_ready) begin
						if (mismatch_count < 10)
							$display({"mismatch: expected char_out %h not_ready %b, ",
								"got char_out %h not_ready %b"},
								want.char_out, want.not_ready,
								result.char_out, result.not_ready);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			pending_results <= expected_results.size();
		end
	end

endmodule

// ===== tb/sv/keyword_substitution_cipher_top_test.sv =====
module keyword_substitution_cipher_top_test;
	import kwc_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1650;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	request_t    request = '0;
	logic        busy;
	logic        done;
	result_t     result;
	int unsigned mismatch_count;
	int unsigned pending_results;
	int unsigned idle_pct = 0;
	int unsigned sent = 0;

	always #5 clk = ~clk;

	keyword_substitution_cipher_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	cipher_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.request         (request),
		.busy            (busy),
		.done            (done),
		.result          (result),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(1) ? LOWER_BASE : UPPER_BASE) + 8'($urandom_range(25));
	endfunction

	task automatic send_request(input logic [2:0] mode, input logic [7:0] ch);
		int unsigned gap;
		start   <= 1'b1;
		request <= request_t'{mode: mode, char_in: ch};
		@(posedge clk);
		while (busy) @(posedge clk);
		if (mode <= MODE_DEC)
			sent++;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 5);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
	endtask

	// clear, key letters with some noise bytes, finish (sometimes left out), then text
	task automatic keyed_run();
		int unsigned n;
		send_request(MODE_CLEAR, 8'($urandom));
		n = $urandom_range(0, 14);
		repeat (n)
			send_request(MODE_KEY, $urandom_range(9) == 0 ? 8'($urandom) : rand_letter());
		if ($urandom_range(7) != 0)
			send_request(MODE_FINISH, 8'($urandom));
		n = $urandom_range(1, 40);
		repeat (n)
			send_request($urandom_range(1) ? MODE_ENC : MODE_DEC,
				$urandom_range(3) == 0 ? 8'($urandom) : rand_letter());
	endtask

	task automatic noise_run();
		int unsigned n;
		n = $urandom_range(1, 10);
		repeat (n)
			send_request(3'($urandom), 8'($urandom));
	endtask

	initial begin
		int unsigned pause_mark;
		pause_mark = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cipher requests before any key, then unused modes, a key with edge bytes, finish and cipher checks
		send_request(MODE_ENC, "a");
		send_request(MODE_DEC, "Z");
		send_request(3'd5, "A");
		send_request(3'd6, 8'hff);
		send_request(3'd7, 8'h00);
		send_request(MODE_CLEAR, 8'h00);
		send_request(MODE_KEY, "Z");
		send_request(MODE_KEY, "z");
		send_request(MODE_KEY, "@");
		send_request(MODE_KEY, 8'h00);
		send_request(MODE_KEY, 8'hff);
		send_request(MODE_KEY, "[");
		send_request(MODE_KEY, 8'h60);
		send_request(MODE_KEY, "{");
		send_request(MODE_KEY, "m");
		send_request(MODE_KEY, "A");
		send_request(MODE_FINISH, 8'h00);
		send_request(MODE_FINISH, 8'hff);
		send_request(MODE_KEY, "q");
		drain_results();
		send_request(MODE_ENC, "A");
		send_request(MODE_ENC, "z");
		send_request(MODE_ENC, 8'hff);
		send_request(MODE_DEC, "A");
		send_request(MODE_DEC, "Z");
		send_request(MODE_DEC, "a");
		send_request(MODE_DEC, 8'h80);
		drain_results();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ((sent / 150) % 4)
				0: idle_pct = 0;
				1: idle_pct = 67;
				2: idle_pct = 0;
				default: idle_pct = 35;
			endcase
			if ($urandom_range(4) == 0)
				noise_run();
			else
				keyed_run();
			if (sent / 400 != pause_mark) begin
				pause_mark = sent / 400;
				drain_results();
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
